// ----- rtl/qpb_pkg.sv -----
// Shared types, constants and helpers for the quadrature phase binning block.
// No dependencies.
package qpb_pkg;

  localparam int unsigned MaxCardBins  = 32;
  localparam int unsigned MaxRespBins  = 32;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned CordicSteps  = 24;
  localparam int unsigned CordicWidth  = 49;
  localparam int unsigned FrontLatency = CordicSteps + 3;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned AddrBits     = 5;

  typedef enum logic [2:0] {
    REG_CARD_COUNT  = 3'd0,
    REG_RESP_COUNT  = 3'd1,
    REG_CARD_OFFSET = 3'd2,
    REG_RESP_OFFSET = 3'd3,
    REG_CARD_SWAP   = 3'd4,
    REG_RESP_SWAP   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [5:0]  card_count;
    logic [5:0]  resp_count;
    logic [15:0] card_offset;
    logic [15:0] resp_offset;
    logic        card_swap;
    logic        resp_swap;
  } cfg_t;

  function automatic logic [8:0] clamp_bins(logic [5:0] cnt, int unsigned lim);
    logic [8:0] n;
    n = {3'd0, cnt};
    if (cnt == 6'd0) begin
      n = 9'd1;
    end else if (32'(cnt) > lim) begin
      n = 9'(lim);
    end
    return n;
  endfunction

  function automatic logic [31:0] step_angle(int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051D;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/qpb_cordic.sv -----
// Pipelined vectoring CORDIC for one quadrature pair, then offset and sector bin.
// Depends on qpb_pkg.
module qpb_cordic #(
  parameter int unsigned SAMPLE_BITS = qpb_pkg::SampleBits,
  parameter int unsigned MAX_BINS    = qpb_pkg::MaxCardBins,
  parameter int unsigned BW          = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] y_i,
  input  logic                          swap_i,
  input  logic [15:0]                   offset_i,
  input  logic [5:0]                    count_i,
  output logic [BW-1:0]                 bin_o
);

  localparam int unsigned W  = qpb_pkg::CordicWidth;
  localparam int unsigned N  = qpb_pkg::CordicSteps;
  localparam int unsigned SH = 46 - SAMPLE_BITS;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic [31:0]         a_q [N+1];
  logic                z_q [N+1];

  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [W-1:0]           xw, yw;
  logic [31:0]                   rnd;
  logic [15:0]                   ph_q;
  logic [8:0]                    n;
  logic [24:0]                   prod;
  logic [BW-1:0]                 bin_q;

  always_comb begin
    xs = swap_i ? y_i : x_i;
    ys = swap_i ? x_i : y_i;
    xw = W'(xs) <<< SH;
    yw = W'(ys) <<< SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (xs == '0) && (ys == '0);
      if (xw[W-1]) begin
        x_q[0] <= -xw;
        y_q[0] <= -yw;
        a_q[0] <= 32'h80000000;
      end else begin
        x_q[0] <= xw;
        y_q[0] <= yw;
        a_q[0] <= 32'h0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [31:0] Ang = qpb_pkg::step_angle(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1] <= z_q[i];
        if (!y_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] + Ang;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] - Ang;
        end
      end
    end
  end

  assign rnd  = a_q[N] + 32'h00008000;
  assign n    = qpb_pkg::clamp_bins(count_i, MAX_BINS);
  assign prod = 25'(ph_q) * 25'(n);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q  <= z_q[N] ? offset_i : rnd[31:16] + offset_i;
      bin_q <= prod[16 +: BW];
    end
  end

  assign bin_o = bin_q;

endmodule

// ----- rtl/qpb_front.sv -----
// Front end: two phase pipelines in lockstep with a valid and series-end chain.
// Depends on qpb_pkg and qpb_cordic.
module qpb_front #(
  parameter int unsigned SAMPLE_BITS   = qpb_pkg::SampleBits,
  parameter int unsigned MAX_CARD_BINS = qpb_pkg::MaxCardBins,
  parameter int unsigned MAX_RESP_BINS = qpb_pkg::MaxRespBins,
  parameter int unsigned BWC = (MAX_CARD_BINS > 1) ? $clog2(MAX_CARD_BINS) : 1,
  parameter int unsigned BWR = (MAX_RESP_BINS > 1) ? $clog2(MAX_RESP_BINS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qpb_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] resp_x_i,
  input  logic signed [SAMPLE_BITS-1:0] resp_y_i,
  input  logic signed [SAMPLE_BITS-1:0] card_x_i,
  input  logic signed [SAMPLE_BITS-1:0] card_y_i,
  input  logic                          last_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [BWR-1:0]                rb_o,
  output logic [BWC-1:0]                cb_o,
  output logic                          last_o
);

  localparam int unsigned L = qpb_pkg::FrontLatency;

  logic [L-1:0] v_q, last_q;
  logic         en;

  assign en      = !v_q[L-1] || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[L-2:0], last_i};
    end
  end

  qpb_cordic #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_BINS(MAX_RESP_BINS), .BW(BWR)) u_resp (
    .clk_i, .en_i(en), .x_i(resp_x_i), .y_i(resp_y_i), .swap_i(cfg_i.resp_swap),
    .offset_i(cfg_i.resp_offset), .count_i(cfg_i.resp_count), .bin_o(rb_o)
  );

  qpb_cordic #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_BINS(MAX_CARD_BINS), .BW(BWC)) u_card (
    .clk_i, .en_i(en), .x_i(card_x_i), .y_i(card_y_i), .swap_i(cfg_i.card_swap),
    .offset_i(cfg_i.card_offset), .count_i(cfg_i.card_count), .bin_o(cb_o)
  );

  assign valid_o = v_q[L-1];
  assign last_o  = last_q[L-1];

endmodule

// ----- rtl/qpb_fifo.sv -----
// Short transfer queue between front end and histogram.
// Depends on qpb_pkg.
module qpb_fifo #(
  parameter int unsigned DW    = 11,
  parameter int unsigned DEPTH = qpb_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [DW-1:0] data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] buf_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign ready_o = cnt_q != CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/qpb_hist.sv -----
// Back end: histogram memory with read-modify-write, forwarding, running maximum,
// clearing sweep and output register. Depends on qpb_pkg.
module qpb_hist #(
  parameter int unsigned MAX_CARD_BINS = qpb_pkg::MaxCardBins,
  parameter int unsigned MAX_RESP_BINS = qpb_pkg::MaxRespBins,
  parameter int unsigned COUNT_BITS    = qpb_pkg::CountBits,
  parameter int unsigned BWC = (MAX_CARD_BINS > 1) ? $clog2(MAX_CARD_BINS) : 1,
  parameter int unsigned BWR = (MAX_RESP_BINS > 1) ? $clog2(MAX_RESP_BINS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [BWR-1:0]        rb_i,
  input  logic [BWC-1:0]        cb_i,
  input  logic                  last_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [BWC-1:0]        cb_o,
  output logic [BWR-1:0]        rb_o,
  output logic [COUNT_BITS-1:0] max_o,
  output logic                  done_o
);

  localparam int unsigned DEPTH = MAX_CARD_BINS * MAX_RESP_BINS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rd_q, fwd_val_q, max_q, omax_q, cur, nxt, mx;
  logic [AW-1:0]         a_idx, b_idx_q, fwd_addr_q, clr_addr_q;
  logic [BWR-1:0]        b_rb_q, orb_q;
  logic [BWC-1:0]        b_cb_q, ocb_q;
  logic                  b_vld_q, b_last_q, fwd_vld_q, clr_q, ovld_q, odone_q;
  logic                  pop, b_go;

  assign a_idx   = AW'(rb_i) * AW'(MAX_CARD_BINS) + AW'(cb_i);
  assign b_go    = b_vld_q && (!ovld_q || ready_i);
  assign pop     = valid_i && !clr_q && !(b_vld_q && b_last_q) && (!b_vld_q || b_go);
  assign ready_o = pop;

  always_comb begin
    cur = (fwd_vld_q && (fwd_addr_q == b_idx_q)) ? fwd_val_q : rd_q;
    nxt = (cur == CntMax) ? cur : cur + 1'b1;
    mx  = (nxt > max_q) ? nxt : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q    <= 1'b0;
      b_last_q   <= 1'b0;
      ovld_q     <= 1'b0;
      fwd_vld_q  <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      max_q      <= '0;
    end else begin
      if (pop) begin
        b_vld_q  <= 1'b1;
        b_last_q <= last_i;
      end else if (b_go) begin
        b_vld_q  <= 1'b0;
      end
      if (b_go) begin
        ovld_q <= 1'b1;
      end else if (ready_i) begin
        ovld_q <= 1'b0;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
        fwd_vld_q <= 1'b0;
      end else if (b_go) begin
        fwd_vld_q <= !b_last_q;
        max_q     <= b_last_q ? '0 : mx;
        if (b_last_q) begin
          clr_q      <= 1'b1;
          clr_addr_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q    <= mem_q[a_idx];
      b_idx_q <= a_idx;
      b_rb_q  <= rb_i;
      b_cb_q  <= cb_i;
    end
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (b_go) begin
      mem_q[b_idx_q] <= nxt;
    end
    if (b_go) begin
      fwd_addr_q <= b_idx_q;
      fwd_val_q  <= nxt;
      orb_q      <= b_rb_q;
      ocb_q      <= b_cb_q;
      omax_q     <= mx;
      odone_q    <= b_last_q;
    end
  end

  assign valid_o = ovld_q;
  assign cb_o    = ocb_q;
  assign rb_o    = orb_q;
  assign max_o   = omax_q;
  assign done_o  = odone_q;

endmodule

// ----- rtl/quadrature_phase_binning.sv -----
// Quadrature phase binning: phases of two pairs via CORDIC, sector bins and a joint
// bin histogram with running maximum. Sustains one sample per clock within a series
// while out_ready_i is not held low. Path: 27-stage phase pipeline, queue, histogram
// read, output register. After reset and after each series_end result a clearing
// sweep runs over all MAX_RESP_BINS*MAX_CARD_BINS words of the histogram memory
// before the next sample is counted; inputs keep filling the pipeline meanwhile.
// Depends on qpb_pkg, qpb_front, qpb_fifo, qpb_hist.
module quadrature_phase_binning #(
  parameter int unsigned MAX_CARD_BINS = qpb_pkg::MaxCardBins,
  parameter int unsigned MAX_RESP_BINS = qpb_pkg::MaxRespBins,
  parameter int unsigned SAMPLE_BITS   = qpb_pkg::SampleBits,
  parameter int unsigned COUNT_BITS    = qpb_pkg::CountBits,
  parameter int unsigned BWC = (MAX_CARD_BINS > 1) ? $clog2(MAX_CARD_BINS) : 1,
  parameter int unsigned BWR = (MAX_RESP_BINS > 1) ? $clog2(MAX_RESP_BINS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qpb_pkg::AddrBits-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   resp_x_i,
  input  logic signed [SAMPLE_BITS-1:0]   resp_y_i,
  input  logic signed [SAMPLE_BITS-1:0]   card_x_i,
  input  logic signed [SAMPLE_BITS-1:0]   card_y_i,
  input  logic                            series_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [BWC-1:0]                  cardiac_bin_o,
  output logic [BWR-1:0]                  resp_bin_o,
  output logic [COUNT_BITS-1:0]           largest_bin_size_o,
  output logic                            series_done_o
);

  localparam int unsigned DW = 1 + BWR + BWC;

  qpb_pkg::cfg_t     cfg_q;
  qpb_pkg::reg_idx_e ridx;
  logic              wr_en;

  logic           f_vld, f_rdy, f_last, q_vld, q_rdy;
  logic [BWR-1:0] f_rb;
  logic [BWC-1:0] f_cb;
  logic [DW-1:0]  q_data;

  assign pready = 1'b1;
  assign ridx   = qpb_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{card_count: 6'd1, resp_count: 6'd1, card_offset: 16'd0,
                 resp_offset: 16'd0, card_swap: 1'b0, resp_swap: 1'b0};
    end else if (wr_en) begin
      case (ridx)
        qpb_pkg::REG_CARD_COUNT:  cfg_q.card_count  <= pwdata[5:0];
        qpb_pkg::REG_RESP_COUNT:  cfg_q.resp_count  <= pwdata[5:0];
        qpb_pkg::REG_CARD_OFFSET: cfg_q.card_offset <= pwdata[15:0];
        qpb_pkg::REG_RESP_OFFSET: cfg_q.resp_offset <= pwdata[15:0];
        qpb_pkg::REG_CARD_SWAP:   cfg_q.card_swap   <= pwdata[0];
        qpb_pkg::REG_RESP_SWAP:   cfg_q.resp_swap   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      qpb_pkg::REG_CARD_COUNT:  prdata = {26'd0, cfg_q.card_count};
      qpb_pkg::REG_RESP_COUNT:  prdata = {26'd0, cfg_q.resp_count};
      qpb_pkg::REG_CARD_OFFSET: prdata = {16'd0, cfg_q.card_offset};
      qpb_pkg::REG_RESP_OFFSET: prdata = {16'd0, cfg_q.resp_offset};
      qpb_pkg::REG_CARD_SWAP:   prdata = {31'd0, cfg_q.card_swap};
      qpb_pkg::REG_RESP_SWAP:   prdata = {31'd0, cfg_q.resp_swap};
      default:                  prdata = 32'd0;
    endcase
  end

  qpb_front #(
    .SAMPLE_BITS(SAMPLE_BITS), .MAX_CARD_BINS(MAX_CARD_BINS),
    .MAX_RESP_BINS(MAX_RESP_BINS), .BWC(BWC), .BWR(BWR)
  ) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .resp_x_i, .resp_y_i, .card_x_i, .card_y_i, .last_i(series_end_i),
    .valid_o(f_vld), .ready_i(f_rdy), .rb_o(f_rb), .cb_o(f_cb), .last_o(f_last)
  );

  qpb_fifo #(.DW(DW)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i(f_vld), .ready_o(f_rdy), .data_i({f_last, f_rb, f_cb}),
    .valid_o(q_vld), .ready_i(q_rdy), .data_o(q_data)
  );

  qpb_hist #(
    .MAX_CARD_BINS(MAX_CARD_BINS), .MAX_RESP_BINS(MAX_RESP_BINS),
    .COUNT_BITS(COUNT_BITS), .BWC(BWC), .BWR(BWR)
  ) u_hist (
    .clk_i, .rst_ni,
    .valid_i(q_vld), .ready_o(q_rdy),
    .rb_i(q_data[BWC +: BWR]), .cb_i(q_data[BWC-1:0]), .last_i(q_data[DW-1]),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .cb_o(cardiac_bin_o), .rb_o(resp_bin_o),
    .max_o(largest_bin_size_o), .done_o(series_done_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> largest_bin_size_o != '0)
    else $error("result with empty maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && series_done_o |=> !out_valid_o)
    else $error("result during histogram clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 9'(resp_bin_o) < qpb_pkg::clamp_bins(cfg_q.resp_count, MAX_RESP_BINS))
    else $error("respiratory bin out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 9'(cardiac_bin_o) < qpb_pkg::clamp_bins(cfg_q.card_count, MAX_CARD_BINS))
    else $error("cardiac bin out of range");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for quadrature_phase_binning: random and directed samples
// are checked against a bit-accurate CORDIC, binning and histogram predictor.
// Depends on qpb_pkg and the quadrature_phase_binning RTL.
`timescale 1ns / 1ps

class phase_bin_scoreboard;
  typedef struct {
    logic [4:0]  card_bin;
    logic [4:0]  resp_bin;
    logic [15:0] largest;
    logic        done;
  } bin_result_t;

  logic [31:0] angles[24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

  logic [5:0]  card_count = 6'd1;
  logic [5:0]  resp_count = 6'd1;
  logic [15:0] card_offset = '0;
  logic [15:0] resp_offset = '0;
  logic        card_swap = 1'b0;
  logic        resp_swap = 1'b0;
  int unsigned hist[1024];
  int unsigned peak = 0;
  bin_result_t pending[$];
  int          errors = 0;

  function void write_reg(int unsigned idx, logic [31:0] val);
    case (idx)
      qpb_pkg::REG_CARD_COUNT:  card_count = val[5:0];
      qpb_pkg::REG_RESP_COUNT:  resp_count = val[5:0];
      qpb_pkg::REG_CARD_OFFSET: card_offset = val[15:0];
      qpb_pkg::REG_RESP_OFFSET: resp_offset = val[15:0];
      qpb_pkg::REG_CARD_SWAP:   card_swap = val[0];
      qpb_pkg::REG_RESP_SWAP:   resp_swap = val[0];
      default: ;
    endcase
  endfunction

  function logic [15:0] phase_turns(longint x, longint y);
    logic [31:0] acc;
    longint dx, dy;
    acc = '0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * (longint'(1) << 30);
    y = y * (longint'(1) << 30);
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        acc += angles[i];
      end else begin
        x -= dx;
        y += dy;
        acc -= angles[i];
      end
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function logic [4:0] sector_of(longint a, longint b, logic swap, logic [15:0] off,
                                 logic [5:0] cnt);
    logic [31:0] n;
    logic [15:0] p;
    logic [31:0] prod;
    n = (cnt == 0) ? 1 : (cnt > 32) ? 32 : cnt;
    p = swap ? phase_turns(b, a) : phase_turns(a, b);
    p = p + off;
    prod = p * n;
    return prod[20:16];
  endfunction

  function void note_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                            logic signed [15:0] cx, logic signed [15:0] cy, logic last);
    bin_result_t r;
    int unsigned idx;
    r.resp_bin = sector_of(rx, ry, resp_swap, resp_offset, resp_count);
    r.card_bin = sector_of(cx, cy, card_swap, card_offset, card_count);
    idx = r.resp_bin * 32 + r.card_bin;
    if (hist[idx] < 65535) hist[idx]++;
    if (hist[idx] > peak) peak = hist[idx];
    r.largest = peak[15:0];
    r.done = last;
    pending.push_back(r);
    if (last) begin
      foreach (hist[i]) hist[i] = 0;
      peak = 0;
    end
  endfunction

  function void check_result(logic [4:0] cb, logic [4:0] rb, logic [15:0] lg, logic sd);
    bin_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transfer");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (cb !== e.card_bin) begin
      $error("cardiac_bin expected %0d actual %0d", e.card_bin, cb);
      errors++;
    end
    if (rb !== e.resp_bin) begin
      $error("resp_bin expected %0d actual %0d", e.resp_bin, rb);
      errors++;
    end
    if (lg !== e.largest) begin
      $error("largest_bin_size expected %0d actual %0d", e.largest, lg);
      errors++;
    end
    if (sd !== e.done) begin
      $error("series_done expected %0d actual %0d", e.done, sd);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned Settle = 40;
  localparam int unsigned RegUnused = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [qpb_pkg::AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] resp_x_i = '0, resp_y_i = '0, card_x_i = '0, card_y_i = '0;
  logic series_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [4:0] cardiac_bin_o, resp_bin_o;
  logic [15:0] largest_bin_size_o;
  logic series_done_o;

  phase_bin_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned idle_in = 0, idle_out = 0;

  quadrature_phase_binning i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(cardiac_bin_o, resp_bin_o, largest_bin_size_o, series_done_o);
      out_ready_i <= ($urandom_range(99) >= idle_out);
    end
  end

  task automatic apb_write(int unsigned idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= qpb_pkg::AddrBits'(idx * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] cx,
                             logic [15:0] cy, logic last);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    resp_x_i <= rx;
    resp_y_i <= ry;
    card_x_i <= cx;
    card_y_i <= cy;
    series_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(rx, ry, cx, cy, last);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic configure(logic [5:0] cc, logic [5:0] rc, logic [15:0] co,
                           logic [15:0] ro, logic cs, logic rs);
    apb_write(qpb_pkg::REG_CARD_COUNT, {$urandom_range(3) == 0 ? 26'($urandom) : 26'd0, cc});
    apb_write(qpb_pkg::REG_RESP_COUNT, {26'd0, rc});
    apb_write(qpb_pkg::REG_CARD_OFFSET, {16'($urandom), co});
    apb_write(qpb_pkg::REG_RESP_OFFSET, {16'd0, ro});
    apb_write(qpb_pkg::REG_CARD_SWAP, {31'd0, cs});
    apb_write(qpb_pkg::REG_RESP_SWAP, {31'($urandom), rs});
    apb_write(RegUnused, $urandom);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++)
      send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                  $urandom_range(29) == 0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axes, extremes, zero vector, swap and series end
    configure(6'd32, 6'd32, 16'd0, 16'd0, 1'b0, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_sample(16'h0001, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    drain();
    configure(6'd1, 6'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_sample(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
    send_sample(16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
    drain();
    configure(6'd63, 6'd33, 16'h8000, 16'h0001, 1'b0, 1'b1);
    send_sample(16'h1234, 16'hEDCC, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
    drain();

    // one bin pair hit repeatedly
    configure(6'd1, 6'd1, 16'd0, 16'd0, 1'b0, 1'b0);
    for (int k = 0; k < 60; k++)
      send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b0);
    send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_in = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 13) : 0;
      idle_out = (ph == 2 || ph == 3) ? ((ph == 2) ? 71 : 13) : 0;
      case (ph)
        0: configure(6'd32, 6'd32, 16'hFFFF, 16'd0, 1'b1, 1'b0);
        2: configure(6'd0, 6'd63, 16'd0, 16'hFFFF, 1'b0, 1'b1);
        default: configure(6'($urandom_range(34)), 6'($urandom_range(34)), 16'($urandom),
                           16'($urandom), 1'($urandom), 1'($urandom));
      endcase
      random_phase(100);
      drain();
      if (ph != 0)
        configure(6'($urandom), 6'($urandom_range(1, 32)), 16'($urandom), 16'($urandom),
                  1'($urandom), 1'($urandom));
      else
        configure(6'd2, 6'd3, 16'd0, 16'd0, 1'b0, 1'b1);
      random_phase(100);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
